### rtl/core/spmq_pkg.sv
// Package for the stable priority message queue.
// Holds the queue depth, the status and kind codes, and the transfer structs.
// No dependencies.
`default_nettype none

package spmq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] entry_priority;
		logic [7:0] entry_tag;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] head_priority;
		logic [7:0] head_tag;
		logic [4:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0] priority_val;
		logic [7:0] tag;
	} entry_t;

	// Broadcast from the control to every cell of the chain.
	typedef struct packed {
		logic   ins_en;
		logic   rem_en;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/stable_priority_message_queue.sv
// Stable priority message queue: a chain of compare-and-shift cells in service order.
// A result is registered and appears in the cycle after its command transfer is accepted.
// Throughput: one insert or remove per cycle; the command side stalls only while
// an earlier result is held.
// Reset empties the queue (count to zero) and drops any pending result; the
// slot contents are not cleared. Depends on spmq_pkg and spmq_cell.
`default_nettype none

module stable_priority_message_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire spmq_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output spmq_pkg::rsp_t      rsp
);
	import spmq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             is_full;
	logic             is_empty;
	cell_ctl_t        ctl;
	logic [DEPTH-1:0] occupied;
	logic [DEPTH-1:0] keep;
	entry_t           entries [DEPTH];
	logic [CNT_W-1:0] count_next;
	rsp_t             rsp_next;

	// The command side is held off only while a finished result has not yet
	// been taken; a result leaving in this cycle frees the output register.
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);

	assign ctl.ins_en    = accept && (cmd.kind == KIND_INSERT) && !is_full;
	assign ctl.rem_en    = accept && (cmd.kind == KIND_REMOVE) && !is_empty;
	assign ctl.new_entry = '{priority_val: cmd.entry_priority, tag: cmd.entry_tag};

	// The chain of cells. Slot 0 is the head. A cell counts as occupied when
	// its index is below the stored count, so no per-slot valid bits exist.
	// The head has no left neighbor, so it takes a new entry whenever it does
	// not keep its own; the tail pulls in an unused value on a remove.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic   left_keep;
			entry_t left_entry;
			entry_t right_entry;

			assign occupied[gi] = (count_q > CNT_W'(gi));

			if (gi == 0) begin : g_head
				assign left_keep  = 1'b0;
				assign left_entry = ctl.new_entry;
			end else begin : g_body
				assign left_keep  = keep[gi-1];
				assign left_entry = entries[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_entry = '0;
			end else begin : g_inner
				assign right_entry = entries[gi+1];
			end

			spmq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (occupied[gi]),
				.left_keep   (left_keep),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.keep        (keep[gi]),
				.entry       (entries[gi])
			);
		end
	endgenerate

	// Count update and the result of the accepted command.
	always_comb begin
		count_next = count_q;
		rsp_next   = '0;
		if (ctl.ins_en) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.rem_en) begin
			count_next             = count_q - CNT_W'(1);
			rsp_next.head_priority = entries[0].priority_val;
			rsp_next.head_tag      = entries[0].tag;
		end
		if (cmd.kind == KIND_INSERT) begin
			rsp_next.status = is_full ? ST_FULL : ST_DONE;
		end else begin
			rsp_next.status = is_empty ? ST_EMPTY : ST_DONE;
		end
		rsp_next.occupancy = 5'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: loaded only on an accepted command, so it holds while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The stored count never goes beyond the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	// A rejected insert or an empty remove leaves the count alone.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ctl.ins_en && !ctl.rem_en |=> count_q == $past(count_q))
		else $error("count changed on a rejected command");

	// The count rises by exactly one on a successful insert.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("count did not rise on insert");

	// An insert into an empty queue lands in the head cell.
	a_empty_insert_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en && is_empty |=> entries[0] == $past(ctl.new_entry))
		else $error("insert into empty queue missed the head cell");

	// A successful remove reports the head cell's entry in the next result.
	a_remove_reports_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem_en |=> rsp_valid && rsp.status == ST_DONE
			&& rsp.head_priority == $past(entries[0].priority_val)
			&& rsp.head_tag == $past(entries[0].tag))
		else $error("removed entry does not match the head cell");

endmodule

`default_nettype wire

### rtl/core/spmq_cell.sv
// One slot of the sorted chain: holds an entry and decides whether to keep it,
// take the new entry, or take a neighbor's entry. Depends on spmq_pkg.
`default_nettype none

module spmq_cell (
	input  wire logic               clk,
	input  wire spmq_pkg::cell_ctl_t ctl,
	input  wire logic               occupied,
	input  wire logic               left_keep,
	input  wire spmq_pkg::entry_t   left_entry,
	input  wire spmq_pkg::entry_t   right_entry,
	output logic                    keep,
	output spmq_pkg::entry_t        entry
);
	import spmq_pkg::*;

	entry_t entry_q;

	// A cell keeps its entry on insert when it holds one of equal or higher
	// priority; the kept cells form a prefix because the chain is sorted.
	assign keep  = occupied && (entry_q.priority_val >= ctl.new_entry.priority_val);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && !keep) begin
			entry_q <= left_keep ? ctl.new_entry : left_entry;
		end else if (ctl.rem_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire
